// ===== hw/rtl/ssp_pkg.sv =====
// Shared constants, codes, sideband types and helpers for the sprite projection pipeline.
package ssp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int MIN_DEPTH_DEF = 6554;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAMERA_X     = 3'd0,
        CFG_CAMERA_Y     = 3'd1,
        CFG_DIR_X        = 3'd2,
        CFG_DIR_Y        = 3'd3,
        CFG_PLANE_X      = 3'd4,
        CFG_PLANE_Y      = 3'd5,
        CFG_SCREEN_WIDTH = 3'd6,
        CFG_HORIZON_ROW  = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_VISIBLE   = 2'd0,
        ST_DEGENERATE = 2'd1,
        ST_BEHIND    = 2'd2,
        ST_ZERO_SIZE = 2'd3
    } t_status;

    // Sideband of the lateral-offset divider.
    typedef struct packed {
        logic ovf;
        logic neg;
    } t_tx_side;

    // Sideband of the depth divider.
    typedef struct packed {
        logic        degen;
        logic        ovf;
        logic        neg;
        logic [11:0] scale;
        logic [12:0] tex_w;
        logic [12:0] tex_h;
    } t_ty_side;

    // Sideband of the height divider.
    typedef struct packed {
        logic        ovf;
        logic        degen;
        logic        behind;
        logic [31:0] depth;
        logic [12:0] tex_w;
        logic [12:0] tex_h;
    } t_h_side;

    // Sideband of the centre-column divider.
    typedef struct packed {
        logic ovf;
        logic neg;
    } t_c_side;

    // Sideband of the width divider.
    typedef struct packed {
        logic        ovf;
        logic        th_zero;
        logic        degen;
        logic        behind;
        logic [31:0] depth;
        logic [14:0] height;
        logic [15:0] centre;
    } t_w_side;

    function automatic logic [31:0] sat33_to_32(input logic [32:0] v);
        logic [31:0] res;
        if (v[32] != v[31]) begin
            res = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic [15:0] sat17_to_16(input logic [16:0] v);
        logic [15:0] res;
        if (v[16] != v[15]) begin
            res = v[16] ? 16'h8000 : 16'h7FFF;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/ssp_div_pipe.sv =====
// Pipelined restoring divider: one quotient bit per stage, with a sideband carried alongside.
module ssp_div_pipe #(
    parameter int DW = 64,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_low,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic [DW-1:0] r_rem  [QW-1];
    logic [DW-1:0] r_den  [QW-1];
    logic [QW-1:0] r_low  [QW-1];
    logic [QW-1:0] r_quo  [QW];
    logic [SW-1:0] r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quo_in;
        logic [SW-1:0] side_in;
        logic [DW:0]   trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in  = i_rem;
            assign den_in  = i_den;
            assign low_in  = i_low;
            assign quo_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign low_in  = r_low[k-1];
            assign quo_in  = r_quo[k-1];
            assign side_in = r_side[k-1];
        end

        // Bring down the next numerator bit, subtract when it fits.
        assign trial = {rem_in, low_in[QW-1]};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k]  <= {quo_in[QW-2:0], ge};
                r_side[k] <= side_in;
            end
        end

        if (k < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
                    r_den[k] <= den_in;
                    r_low[k] <= {low_in[QW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo  = r_quo[QW-1];
    assign o_side = r_side[QW-1];

endmodule

// ===== hw/rtl/ssp_isqrt_pipe.sv =====
// Free-running pipelined integer square root, two radicand bits per stage.
module ssp_isqrt_pipe #(
    parameter int VW = 64
) (
    input  logic            i_clk,
    input  logic [VW-1:0]   i_val,
    output logic [VW/2-1:0] o_root
);

    localparam int RW   = VW / 2;
    localparam int REMW = RW + 2;

    logic [REMW-1:0] r_rem  [RW-1];
    logic [VW-1:0]   r_val  [RW-1];
    logic [RW-1:0]   r_root [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [REMW-1:0] rem_in;
        logic [VW-1:0]   val_in;
        logic [RW-1:0]   root_in;
        logic [REMW+1:0] cur;
        logic [REMW-1:0] trial;
        logic            ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign val_in  = i_val;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign val_in  = r_val[k-1];
            assign root_in = r_root[k-1];
        end

        assign cur   = {rem_in, val_in[VW-1 -: 2]};
        assign trial = {root_in, 2'b01};
        assign ge    = (cur >= {2'b00, trial});

        always_ff @(posedge i_clk) begin
            r_root[k] <= {root_in[RW-2:0], ge};
        end

        if (k < RW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[k] <= ge ? REMW'(cur - {2'b00, trial}) : cur[REMW-1:0];
                r_val[k] <= {val_in[VW-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

// ===== hw/rtl/sprite_screen_projection.sv =====
// Top level: projects one sprite per cycle from world space into screen space, while no result is held.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  config  | in        | i_cfg_we             | i_cfg_idx, i_cfg_data
//  sprite  | in        | i_valid / o_stall    | i_sprite_x/y, i_size_scale, i_tex_width/height
//  result  | out       | o_valid / i_stall    | o_status, o_depth, o_centre_col, box fields
//
// One item enters per cycle while no result is held; it passes through a chain of
// three divider ranks (32 quotient bits for depth and offset, 16 for height and centre, 15 for
// width), one quotient bit per stage, plus the multiply and fix-up stages around them.
// The camera terms (determinant, plane length via a 32-stage square root) run free from
// the configuration registers and settle after a write.
// Reset is synchronous, active low; it clears valid bits and loads the camera defaults.
// A held result freezes the whole pipeline in place; nothing is dropped or repeated.
module sprite_screen_projection #(
    parameter int FRAC_BITS = ssp_pkg::FRAC_BITS_DEF,
    parameter int MIN_DEPTH = ssp_pkg::MIN_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ssp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // sprite in
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [31:0]              i_sprite_x,
    input  logic signed [31:0]              i_sprite_y,
    input  logic [11:0]                     i_size_scale,
    input  logic [12:0]                     i_tex_width,
    input  logic [12:0]                     i_tex_height,
    // result out
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [1:0]                      o_status,
    output logic signed [31:0]              o_depth,
    output logic signed [15:0]              o_centre_col,
    output logic [14:0]                     o_box_width,
    output logic [14:0]                     o_box_height,
    output logic signed [15:0]              o_left_col,
    output logic signed [15:0]              o_right_col,
    output logic signed [15:0]              o_top_row,
    output logic signed [15:0]              o_bottom_row
);

    // Offset-to-quotient alignment: the quotient keeps FRAC_BITS fraction bits and
    // is bounded to 32 bits, so the divider starts from num >> (32 - FRAC_BITS).
    localparam int SH_DIFF = 32 - FRAC_BITS;
    localparam int DL_W    = 64 + SH_DIFF;
    // Height numerator W*s (Q4.8) lifted to 2F-1 fraction bits over len*ty.
    localparam int H_SHIFT = 2 * FRAC_BITS - 9;
    localparam int HN_W    = 25 + H_SHIFT;
    localparam logic [63:0] DET_EPS = ((64'd1 << (2 * FRAC_BITS)) + 64'd9999) / 64'd10000;

    localparam int T_QW = 32;
    localparam int H_QW = 16;
    localparam int W_QW = 15;
    localparam int LAT  = 5 + T_QW + 5 + H_QW + 2 + W_QW + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] r_cam_x, r_cam_y, r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [12:0] r_scr_w;
    logic [15:0] r_horizon;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x   <= 32'd0;
            r_cam_y   <= 32'd0;
            r_dir_x   <= 32'd65536;
            r_dir_y   <= 32'd0;
            r_plane_x <= 32'd0;
            r_plane_y <= 32'd43254;
            r_scr_w   <= 13'd640;
            r_horizon <= 16'd240;
        end else if (i_cfg_we) begin
            unique case (ssp_pkg::t_cfg_idx'(i_cfg_idx))
                ssp_pkg::CFG_CAMERA_X:     r_cam_x   <= i_cfg_data;
                ssp_pkg::CFG_CAMERA_Y:     r_cam_y   <= i_cfg_data;
                ssp_pkg::CFG_DIR_X:        r_dir_x   <= i_cfg_data;
                ssp_pkg::CFG_DIR_Y:        r_dir_y   <= i_cfg_data;
                ssp_pkg::CFG_PLANE_X:      r_plane_x <= i_cfg_data;
                ssp_pkg::CFG_PLANE_Y:      r_plane_y <= i_cfg_data;
                ssp_pkg::CFG_SCREEN_WIDTH: r_scr_w   <= i_cfg_data[12:0];
                ssp_pkg::CFG_HORIZON_ROW:  r_horizon <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Camera terms, free running (config only changes while empty: a user rule, not enforced here)
    // ------------------------------------------------------------------
    logic [63:0] r_c1_pd, r_c1_dp, r_c1_sqx, r_c1_sqy;
    logic [63:0] r_c2_det, r_c2_lsum;
    logic [63:0] r_c3_dmag;
    logic        r_c3_dneg;
    logic        r_c4_degen;
    logic [31:0] plane_len;

    always_ff @(posedge i_clk) begin
        r_c1_pd   <= $signed(r_plane_x) * $signed(r_dir_y);
        r_c1_dp   <= $signed(r_dir_x) * $signed(r_plane_y);
        r_c1_sqx  <= $signed(r_plane_x) * $signed(r_plane_x);
        r_c1_sqy  <= $signed(r_plane_y) * $signed(r_plane_y);
        r_c2_det  <= r_c1_pd - r_c1_dp;
        r_c2_lsum <= r_c1_sqx + r_c1_sqy;
        r_c3_dneg <= r_c2_det[63];
        r_c3_dmag <= r_c2_det[63] ? (64'd0 - r_c2_det) : r_c2_det;
        r_c4_degen <= (r_c3_dmag < DET_EPS);
    end

    ssp_isqrt_pipe #(
        .VW (64)
    ) u_len (
        .i_clk  (i_clk),
        .i_val  (r_c2_lsum),
        .o_root (plane_len)
    );

    // ------------------------------------------------------------------
    // Pipeline control: advance everything unless a result is held
    // ------------------------------------------------------------------
    logic           en;
    logic [LAT-1:0] r_vld;

    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // ------------------------------------------------------------------
    // P1..P5: offsets, transform numerators, divider set-up
    // ------------------------------------------------------------------
    logic [31:0] r_p1_dx, r_p1_dy;
    logic [11:0] r_p1_s, r_p2_s, r_p3_s, r_p4_s;
    logic [12:0] r_p1_tw, r_p2_tw, r_p3_tw, r_p4_tw;
    logic [12:0] r_p1_th, r_p2_th, r_p3_th, r_p4_th;
    logic [63:0] r_p2_m0, r_p2_m1, r_p2_m2, r_p2_m3;
    logic [63:0] r_p3_nx, r_p3_ny;
    logic [63:0] r_p4_xmag, r_p4_ymag;
    logic        r_p4_xneg, r_p4_yneg;
    logic [63:0] r_p5_xrem, r_p5_yrem;
    logic [31:0] r_p5_xlow, r_p5_ylow;
    ssp_pkg::t_tx_side r_p5_xside;
    ssp_pkg::t_ty_side r_p5_yside;

    always_ff @(posedge i_clk) begin
        if (en) begin
            // hold the offset inside 32 bits
            r_p1_dx <= ssp_pkg::sat33_to_32({i_sprite_x[31], i_sprite_x} - {r_cam_x[31], r_cam_x});
            r_p1_dy <= ssp_pkg::sat33_to_32({i_sprite_y[31], i_sprite_y} - {r_cam_y[31], r_cam_y});
            r_p1_s  <= i_size_scale;
            r_p1_tw <= i_tex_width;
            r_p1_th <= i_tex_height;

            r_p2_m0 <= $signed(r_dir_y) * $signed(r_p1_dx);
            r_p2_m1 <= $signed(r_dir_x) * $signed(r_p1_dy);
            r_p2_m2 <= $signed(r_plane_x) * $signed(r_p1_dy);
            r_p2_m3 <= $signed(r_plane_y) * $signed(r_p1_dx);
            r_p2_s  <= r_p1_s;
            r_p2_tw <= r_p1_tw;
            r_p2_th <= r_p1_th;

            r_p3_nx <= r_p2_m0 - r_p2_m1;
            r_p3_ny <= r_p2_m2 - r_p2_m3;
            r_p3_s  <= r_p2_s;
            r_p3_tw <= r_p2_tw;
            r_p3_th <= r_p2_th;

            r_p4_xmag <= r_p3_nx[63] ? (64'd0 - r_p3_nx) : r_p3_nx;
            r_p4_ymag <= r_p3_ny[63] ? (64'd0 - r_p3_ny) : r_p3_ny;
            r_p4_xneg <= r_p3_nx[63] ^ r_c3_dneg;
            r_p4_yneg <= r_p3_ny[63] ^ r_c3_dneg;
            r_p4_s    <= r_p3_s;
            r_p4_tw   <= r_p3_tw;
            r_p4_th   <= r_p3_th;

            // a quotient of 2^32 or more saturates; otherwise 32 steps suffice
            r_p5_xrem       <= r_p4_xmag >> SH_DIFF;
            r_p5_yrem       <= r_p4_ymag >> SH_DIFF;
            r_p5_xlow       <= 32'(r_p4_xmag << FRAC_BITS);
            r_p5_ylow       <= 32'(r_p4_ymag << FRAC_BITS);
            r_p5_xside.ovf  <= (DL_W'(r_p4_xmag) >= (DL_W'(r_c3_dmag) << SH_DIFF));
            r_p5_xside.neg  <= r_p4_xneg;
            r_p5_yside.ovf  <= (DL_W'(r_p4_ymag) >= (DL_W'(r_c3_dmag) << SH_DIFF));
            r_p5_yside.neg  <= r_p4_yneg;
            r_p5_yside.degen <= r_c4_degen;
            r_p5_yside.scale <= r_p4_s;
            r_p5_yside.tex_w <= r_p4_tw;
            r_p5_yside.tex_h <= r_p4_th;
        end
    end

    logic [31:0] qx, qy;
    ssp_pkg::t_tx_side dx_side;
    ssp_pkg::t_ty_side dy_side;

    ssp_div_pipe #(
        .DW (64),
        .QW (T_QW),
        .SW ($bits(ssp_pkg::t_tx_side))
    ) u_div_tx (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rem  (r_p5_xrem),
        .i_low  (r_p5_xlow),
        .i_den  (r_c3_dmag),
        .i_side (r_p5_xside),
        .o_quo  (qx),
        .o_side (dx_side)
    );

    ssp_div_pipe #(
        .DW (64),
        .QW (T_QW),
        .SW ($bits(ssp_pkg::t_ty_side))
    ) u_div_ty (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rem  (r_p5_yrem),
        .i_low  (r_p5_ylow),
        .i_den  (r_c3_dmag),
        .i_side (r_p5_yside),
        .o_quo  (qy),
        .o_side (dy_side)
    );

    // ------------------------------------------------------------------
    // X1..X5: signed fix-up, height and centre divider set-up
    // ------------------------------------------------------------------
    logic [31:0] capx, capy, magx, magy;
    logic [63:0] lty;
    logic [HN_W-1:0] nh_sh;

    assign capx = dx_side.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign capy = dy_side.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign magx = (dx_side.ovf || (qx > capx)) ? capx : qx;
    assign magy = (dy_side.ovf || (qy > capy)) ? capy : qy;

    logic [31:0] r_x1_tx, r_x1_ty;
    logic        r_x1_degen;
    logic [11:0] r_x1_s;
    logic [12:0] r_x1_tw, r_x1_th;

    logic [32:0] r_x2_sum;
    logic [63:0] r_x2_lty;
    logic [24:0] r_x2_nh;
    logic [31:0] r_x2_ty;
    logic        r_x2_degen, r_x2_behind;
    logic [12:0] r_x2_tw, r_x2_th;

    logic [32:0] r_x3_asum;
    logic        r_x3_sneg;
    logic [63:0] r_x3_hrem, r_x3_hden;
    logic [15:0] r_x3_hlow;
    ssp_pkg::t_h_side r_x3_hside;

    logic [45:0] r_x4_cnum;
    logic        r_x4_sneg;
    logic [63:0] r_x4_hrem, r_x4_hden;
    logic [15:0] r_x4_hlow;
    ssp_pkg::t_h_side r_x4_hside;

    logic [63:0] r_x5_hrem, r_x5_hden;
    logic [15:0] r_x5_hlow;
    ssp_pkg::t_h_side r_x5_hside;
    logic [32:0] r_x5_crem, r_x5_cden;
    logic [15:0] r_x5_clow;
    ssp_pkg::t_c_side r_x5_cside;

    assign lty   = plane_len * r_x1_ty;
    assign nh_sh = HN_W'(r_x2_nh) << H_SHIFT;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x1_tx    <= dx_side.neg ? (32'd0 - magx) : magx;
            r_x1_ty    <= dy_side.neg ? (32'd0 - magy) : magy;
            r_x1_degen <= dy_side.degen;
            r_x1_s     <= dy_side.scale;
            r_x1_tw    <= dy_side.tex_w;
            r_x1_th    <= dy_side.tex_h;

            r_x2_sum    <= {r_x1_tx[31], r_x1_tx} + {r_x1_ty[31], r_x1_ty};
            r_x2_lty    <= lty;
            r_x2_nh     <= 25'(r_scr_w * r_x1_s);
            r_x2_ty     <= r_x1_ty;
            r_x2_degen  <= r_x1_degen;
            r_x2_behind <= !($signed(r_x1_ty) > $signed(32'(MIN_DEPTH)));
            r_x2_tw     <= r_x1_tw;
            r_x2_th     <= r_x1_th;

            r_x3_asum <= r_x2_sum[32] ? (33'd0 - r_x2_sum) : r_x2_sum;
            r_x3_sneg <= r_x2_sum[32];
            r_x3_hrem <= 64'(nh_sh >> 16);
            r_x3_hlow <= nh_sh[15:0];
            r_x3_hden <= r_x2_lty;
            // a zero length saturates here too
            r_x3_hside.ovf    <= (80'(nh_sh) >= {r_x2_lty, 16'd0});
            r_x3_hside.degen  <= r_x2_degen;
            r_x3_hside.behind <= r_x2_behind;
            r_x3_hside.depth  <= r_x2_ty;
            r_x3_hside.tex_w  <= r_x2_tw;
            r_x3_hside.tex_h  <= r_x2_th;

            r_x4_cnum  <= 46'(r_scr_w * r_x3_asum);
            r_x4_sneg  <= r_x3_sneg;
            r_x4_hrem  <= r_x3_hrem;
            r_x4_hlow  <= r_x3_hlow;
            r_x4_hden  <= r_x3_hden;
            r_x4_hside <= r_x3_hside;

            r_x5_hrem  <= r_x4_hrem;
            r_x5_hlow  <= r_x4_hlow;
            r_x5_hden  <= r_x4_hden;
            r_x5_hside <= r_x4_hside;
            r_x5_crem  <= 33'(r_x4_cnum >> 16);
            r_x5_clow  <= r_x4_cnum[15:0];
            r_x5_cden  <= {r_x4_hside.depth, 1'b0};
            r_x5_cside.ovf <= ({3'd0, r_x4_cnum} >= {r_x4_hside.depth, 1'b0, 16'd0});
            r_x5_cside.neg <= r_x4_sneg;
        end
    end

    logic [15:0] qh, qc;
    ssp_pkg::t_h_side dh_side;
    ssp_pkg::t_c_side dc_side;

    ssp_div_pipe #(
        .DW (64),
        .QW (H_QW),
        .SW ($bits(ssp_pkg::t_h_side))
    ) u_div_h (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rem  (r_x5_hrem),
        .i_low  (r_x5_hlow),
        .i_den  (r_x5_hden),
        .i_side (r_x5_hside),
        .o_quo  (qh),
        .o_side (dh_side)
    );

    ssp_div_pipe #(
        .DW (33),
        .QW (H_QW),
        .SW ($bits(ssp_pkg::t_c_side))
    ) u_div_c (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rem  (r_x5_crem),
        .i_low  (r_x5_clow),
        .i_den  (r_x5_cden),
        .i_side (r_x5_cside),
        .o_quo  (qc),
        .o_side (dc_side)
    );

    // ------------------------------------------------------------------
    // Y1..Y2: height and centre fix-up, width divider set-up
    // ------------------------------------------------------------------
    logic [14:0] height_c;
    logic [16:0] cmag;
    logic [15:0] centre_c;

    assign height_c = (dh_side.ovf || (qh > 16'd32767)) ? 15'h7FFF : qh[14:0];
    assign cmag     = (dc_side.ovf || ({1'b0, qc} > 17'd32768)) ? 17'd32768 : {1'b0, qc};
    assign centre_c = dc_side.neg ? 16'(17'd0 - cmag)
                                  : ((cmag > 17'd32767) ? 16'h7FFF : cmag[15:0]);

    logic [27:0] r_y1_prod;
    logic [12:0] r_y1_th;
    logic [14:0] r_y1_height;
    logic [15:0] r_y1_centre;
    logic [31:0] r_y1_ty;
    logic        r_y1_degen, r_y1_behind;

    logic [12:0] r_y2_wrem, r_y2_wden;
    logic [14:0] r_y2_wlow;
    ssp_pkg::t_w_side r_y2_wside;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_y1_prod   <= 28'(height_c * dh_side.tex_w);
            r_y1_th     <= dh_side.tex_h;
            r_y1_height <= height_c;
            r_y1_centre <= centre_c;
            r_y1_ty     <= dh_side.depth;
            r_y1_degen  <= dh_side.degen;
            r_y1_behind <= dh_side.behind;

            r_y2_wrem <= 13'(r_y1_prod >> 15);
            r_y2_wlow <= r_y1_prod[14:0];
            r_y2_wden <= r_y1_th;
            r_y2_wside.ovf     <= (r_y1_prod >= {r_y1_th, 15'd0});
            r_y2_wside.th_zero <= (r_y1_th == 13'd0);
            r_y2_wside.degen   <= r_y1_degen;
            r_y2_wside.behind  <= r_y1_behind;
            r_y2_wside.depth   <= r_y1_ty;
            r_y2_wside.height  <= r_y1_height;
            r_y2_wside.centre  <= r_y1_centre;
        end
    end

    logic [14:0] qw;
    ssp_pkg::t_w_side dw_side;

    ssp_div_pipe #(
        .DW (13),
        .QW (W_QW),
        .SW ($bits(ssp_pkg::t_w_side))
    ) u_div_w (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rem  (r_y2_wrem),
        .i_low  (r_y2_wlow),
        .i_den  (r_y2_wden),
        .i_side (r_y2_wside),
        .o_quo  (qw),
        .o_side (dw_side)
    );

    // ------------------------------------------------------------------
    // Output register: box edges and status
    // ------------------------------------------------------------------
    logic [14:0] width_c;
    logic [13:0] half_w, half_h;
    logic [15:0] left_c, right_c, top_c, bottom_c;

    assign width_c  = dw_side.th_zero ? 15'd0 : (dw_side.ovf ? 15'h7FFF : qw);
    assign half_w   = width_c[14:1];
    assign half_h   = dw_side.height[14:1];
    assign left_c   = ssp_pkg::sat17_to_16({dw_side.centre[15], dw_side.centre} - {3'd0, half_w});
    assign right_c  = ssp_pkg::sat17_to_16({dw_side.centre[15], dw_side.centre} + {3'd0, half_w});
    assign top_c    = ssp_pkg::sat17_to_16({r_horizon[15], r_horizon} - {3'd0, half_h});
    assign bottom_c = ssp_pkg::sat17_to_16({r_horizon[15], r_horizon} + {3'd0, half_h});

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (dw_side.degen) begin
                // degenerate camera: report the code, zero the rest
                o_status     <= ssp_pkg::ST_DEGENERATE;
                o_depth      <= '0;
                o_centre_col <= '0;
                o_box_width  <= '0;
                o_box_height <= '0;
                o_left_col   <= '0;
                o_right_col  <= '0;
                o_top_row    <= '0;
                o_bottom_row <= '0;
            end else if (dw_side.behind) begin
                // behind or too near: keep only the depth
                o_status     <= ssp_pkg::ST_BEHIND;
                o_depth      <= dw_side.depth;
                o_centre_col <= '0;
                o_box_width  <= '0;
                o_box_height <= '0;
                o_left_col   <= '0;
                o_right_col  <= '0;
                o_top_row    <= '0;
                o_bottom_row <= '0;
            end else begin
                o_status     <= ((width_c == 15'd0) || (dw_side.height == 15'd0))
                                ? ssp_pkg::ST_ZERO_SIZE : ssp_pkg::ST_VISIBLE;
                o_depth      <= dw_side.depth;
                o_centre_col <= dw_side.centre;
                o_box_width  <= width_c;
                o_box_height <= dw_side.height;
                o_left_col   <= left_c;
                o_right_col  <= right_c;
                o_top_row    <= top_c;
                o_bottom_row <= bottom_c;
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_degen_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ssp_pkg::ST_DEGENERATE)) |->
            ((o_depth == 32'sd0) && (o_box_width == 15'd0) && (o_box_height == 15'd0)))
        else $error("degenerate camera result carries nonzero fields");

    a_behind_depth : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ssp_pkg::ST_BEHIND)) |->
            ($signed(o_depth) <= $signed(32'(MIN_DEPTH))))
        else $error("behind status with depth beyond the near limit");

    a_visible_box : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ssp_pkg::ST_VISIBLE)) |->
            ((o_box_width != 15'd0) && (o_box_height != 15'd0) &&
             (o_left_col <= o_right_col) && (o_top_row <= o_bottom_row)))
        else $error("visible sprite with an empty or inverted box");

endmodule

// ===== dv/sprite_screen_projection_tb.sv =====
// Self-checking testbench for the sprite screen projection pipeline.
module sprite_screen_projection_tb;

    localparam int           FRAC      = 16;
    localparam longint       NEAR_LIM  = 6554;
    localparam longint       I32_MIN   = -64'sd2147483648;
    localparam longint       I32_MAX   = 64'sd2147483647;
    // Determinant floor: ceil(0.0001 * 2^(2*FRAC)).
    localparam longint unsigned DET_FLOOR = ((64'd1 << (2 * FRAC)) + 64'd9999) / 64'd10000;

    // Expected result of one sprite.
    typedef struct packed {
        ssp_pkg::t_status status;
        logic [31:0] depth;
        logic [15:0] centre;
        logic [14:0] box_w;
        logic [14:0] box_h;
        logic [15:0] left;
        logic [15:0] right;
        logic [15:0] top;
        logic [15:0] bottom;
    } t_proj;

    // One directed sprite; typed rows carry their result in the table.
    typedef struct {
        logic [31:0] sx;
        logic [31:0] sy;
        logic [11:0] scale;
        logic [12:0] tw;
        logic [12:0] th;
        bit          typed;
        t_proj       res;
    } t_sprite_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [ssp_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [ssp_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic signed [31:0] i_sprite_x = '0;
    logic signed [31:0] i_sprite_y = '0;
    logic [11:0] i_size_scale = '0;
    logic [12:0] i_tex_width = '0;
    logic [12:0] i_tex_height = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic signed [31:0] o_depth;
    logic signed [15:0] o_centre_col;
    logic [14:0] o_box_width;
    logic [14:0] o_box_height;
    logic signed [15:0] o_left_col;
    logic signed [15:0] o_right_col;
    logic signed [15:0] o_top_row;
    logic signed [15:0] o_bottom_row;

    sprite_screen_projection DUT (.*);

    always #10 i_clk = ~i_clk;

    // Camera copy used by the projection predictor.
    longint          cam_x, cam_y, view_x, view_y, pln_x, pln_y, horizon;
    longint unsigned scr_w;

    t_proj pending_proj[$];
    int    fail_cnt = 0;
    int    idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both lightly

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint unsigned umag(longint v);
        return v < 0 ? 64'd0 - longint'(v) : longint'(v);
    endfunction

    // floor(num * 2^shift / den), capped at cap.
    function automatic longint unsigned shifted_quot(longint unsigned num,
            longint unsigned den, int shift, longint unsigned cap);
        longint unsigned q, r;
        if (den == 0) return cap;
        q = num / den;
        r = num % den;
        if (q > cap) return cap;
        for (int i = 0; i < shift; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
            if (q > cap) return cap;
        end
        return q;
    endfunction

    function automatic longint fixed_quot(longint num, longint den);
        bit neg;
        longint unsigned q;
        neg = (num < 0) != (den < 0);
        q = shifted_quot(umag(num), umag(den), FRAC,
                         neg ? 64'h8000_0000 : 64'h7FFF_FFFF);
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic void apply_cfg(ssp_pkg::t_cfg_idx idx, logic [31:0] d);
        case (idx)
            ssp_pkg::CFG_CAMERA_X:     cam_x = longint'(signed'(d));
            ssp_pkg::CFG_CAMERA_Y:     cam_y = longint'(signed'(d));
            ssp_pkg::CFG_DIR_X:        view_x = longint'(signed'(d));
            ssp_pkg::CFG_DIR_Y:        view_y = longint'(signed'(d));
            ssp_pkg::CFG_PLANE_X:      pln_x = longint'(signed'(d));
            ssp_pkg::CFG_PLANE_Y:      pln_y = longint'(signed'(d));
            ssp_pkg::CFG_SCREEN_WIDTH: scr_w = longint'(d[12:0]);
            default:                   horizon = longint'(signed'(d[15:0]));
        endcase
    endfunction

    // Project one sprite through the current camera.
    function automatic t_proj project(logic [31:0] sx, logic [31:0] sy,
            logic [11:0] s, logic [12:0] tw, logic [12:0] th);
        longint          dx, dy, det, nx, ny, tx, ty, ctr, hw, hh;
        longint unsigned len, h, w, cnum, cq;
        t_proj r;
        r = '0;
        dx = clamp(longint'(signed'(sx)) - cam_x, I32_MIN, I32_MAX);
        dy = clamp(longint'(signed'(sy)) - cam_y, I32_MIN, I32_MAX);
        det = pln_x * view_y - view_x * pln_y;
        if (umag(det) < DET_FLOOR) begin
            r.status = ssp_pkg::ST_DEGENERATE;
            return r;
        end
        nx = view_y * dx - view_x * dy;
        ny = pln_x * dy - pln_y * dx;
        tx = fixed_quot(nx, det);
        ty = fixed_quot(ny, det);
        r.depth = ty[31:0];
        if (ty <= NEAR_LIM) begin
            r.status = ssp_pkg::ST_BEHIND;
            return r;
        end
        len = int_sqrt(longint'(pln_x * pln_x) + longint'(pln_y * pln_y));
        h = shifted_quot(scr_w * longint'(s), len * longint'(ty), 2 * FRAC - 9, 32767);
        w = (th == 0) ? 0 : (h * longint'(tw)) / longint'(th);
        if (w > 32767) w = 32767;
        cnum = scr_w * umag(ty + tx);
        cq = cnum / (2 * longint'(ty));
        ctr = cq > 32768 ? 32768 : longint'(cq);
        if (ty + tx < 0) ctr = -ctr;
        ctr = clamp(ctr, -32768, 32767);
        hw = longint'(w / 2);
        hh = longint'(h / 2);
        r.status = (w == 0 || h == 0) ? ssp_pkg::ST_ZERO_SIZE : ssp_pkg::ST_VISIBLE;
        r.centre = ctr[15:0];
        r.box_w = w[14:0];
        r.box_h = h[14:0];
        r.left = 16'(clamp(ctr - hw, -32768, 32767));
        r.right = 16'(clamp(ctr + hw, -32768, 32767));
        r.top = 16'(clamp(horizon - hh, -32768, 32767));
        r.bottom = 16'(clamp(horizon + hh, -32768, 32767));
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
            fail_cnt++;
        end
    endfunction

    // Compare every accepted result with the oldest pending projection.
    always @(posedge i_clk) begin
        t_proj e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_proj.size() == 0) begin
                $display("%0t: unexpected result, status %0d depth %0h",
                         $time, o_status, o_depth);
                fail_cnt++;
            end else begin
                e = pending_proj.pop_front();
                check_field("status", {30'd0, e.status}, {30'd0, o_status});
                check_field("depth", e.depth, o_depth);
                check_field("centre_col", {16'd0, e.centre}, {16'd0, o_centre_col});
                check_field("box_width", {17'd0, e.box_w}, {17'd0, o_box_width});
                check_field("box_height", {17'd0, e.box_h}, {17'd0, o_box_height});
                check_field("left_col", {16'd0, e.left}, {16'd0, o_left_col});
                check_field("right_col", {16'd0, e.right}, {16'd0, o_right_col});
                check_field("top_row", {16'd0, e.top}, {16'd0, o_top_row});
                check_field("bottom_row", {16'd0, e.bottom}, {16'd0, o_bottom_row});
            end
        end
    end

    // Receiver back-pressure, depending on the phase.
    always @(posedge i_clk) begin
        case (idle_mode)
            2:       i_stall <= ($urandom_range(99) < 80);
            3:       i_stall <= ($urandom_range(99) < 9);
            default: i_stall <= 1'b0;
        endcase
    end

    // Present one sprite, hold it until taken, then record its projection.
    task automatic send_sprite(t_sprite_row row);
        while ((idle_mode == 1 && $urandom_range(99) < 80) ||
               (idle_mode == 3 && $urandom_range(99) < 9)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_sprite_x   <= row.sx;
        i_sprite_y   <= row.sy;
        i_size_scale <= row.scale;
        i_tex_width  <= row.tw;
        i_tex_height <= row.th;
        do @(posedge i_clk); while (o_stall);
        pending_proj.push_back(row.typed ? row.res
                               : project(row.sx, row.sy, row.scale, row.tw, row.th));
    endtask

    task automatic write_camera(logic [31:0] vals[8]);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= ssp_pkg::t_cfg_idx'(i);
            i_cfg_data <= vals[i];
            apply_cfg(ssp_pkg::t_cfg_idx'(i), vals[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        // let the determinant and plane length settle
        repeat (50) @(posedge i_clk);
    endtask

    function automatic logic [31:0] small_signed(int bits);
        longint lim;
        lim = longint'(1) << bits;
        return 32'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
    endfunction

    function automatic t_sprite_row random_sprite();
        t_sprite_row row;
        row.typed = 1'b0;
        row.res = '0;
        if ($urandom_range(99) < 75) begin
            row.sx = 32'(cam_x) + small_signed($urandom_range(14, 24));
            row.sy = 32'(cam_y) + small_signed($urandom_range(14, 24));
        end else begin
            row.sx = $urandom;
            row.sy = $urandom;
        end
        row.scale = ($urandom_range(9) == 0) ? 12'd0 : 12'($urandom_range(1, 4095));
        if ($urandom_range(9) < 2) begin
            row.tw = 13'($urandom);
            row.th = 13'($urandom);
        end else begin
            row.tw = 13'($urandom_range(1, 256));
            row.th = 13'($urandom_range(1, 256));
        end
        return row;
    endfunction

    initial begin
        t_sprite_row  directed[$];
        logic [31:0]  cfg[8];
        t_proj        near_res;

        cam_x = 0; cam_y = 0; view_x = 65536; view_y = 0;
        pln_x = 0; pln_y = 43254; scr_w = 640; horizon = 240;

        // Directed table, reset camera: looking along +x, plane 0.66 along +y.
        near_res = '0;
        near_res.status = ssp_pkg::ST_BEHIND;
        directed.push_back('{32'd0, 32'd0, 12'd256, 13'd64, 13'd64, 1'b1, near_res});
        near_res.depth = 32'hFFFE_0000;
        directed.push_back('{32'hFFFE_0000, 32'd0, 12'd256, 13'd64, 13'd64, 1'b1, near_res});
        near_res.depth = 32'd6554;   // exactly at the near limit
        directed.push_back('{32'd6554, 32'd0, 12'd256, 13'd64, 13'd64, 1'b1, near_res});
        directed.push_back('{32'd6555, 32'd0, 12'd256, 13'd64, 13'd64, 1'b0, '0});
        directed.push_back('{32'h0002_0000, 32'd0, 12'd256, 13'd64, 13'd64, 1'b0, '0});
        directed.push_back('{32'h0002_0000, 32'd0, 12'd0, 13'd64, 13'd64, 1'b0, '0});
        directed.push_back('{32'h0002_0000, 32'd0, 12'd4095, 13'd4096, 13'd4096, 1'b0, '0});
        directed.push_back('{32'h0002_0000, 32'd0, 12'd256, 13'd64, 13'd0, 1'b0, '0});
        directed.push_back('{32'h0002_0000, 32'd0, 12'd256, 13'h1FFF, 13'h1FFF, 1'b0, '0});
        directed.push_back('{32'h0002_0000, 32'h0001_0000, 12'd256, 13'd1, 13'h1FFF, 1'b0, '0});
        directed.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 12'd256, 13'd64, 13'd64, 1'b0, '0});
        directed.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 12'd256, 13'd64, 13'd64, 1'b0, '0});
        directed.push_back('{32'h0001_0000, 32'h7FFF_FFFF, 12'd256, 13'd64, 13'd64, 1'b0, '0});
        directed.push_back('{32'h0001_0000, 32'h8000_0000, 12'd256, 13'd64, 13'd64, 1'b0, '0});
        directed.push_back('{32'd6600, 32'd0, 12'd4095, 13'h1FFF, 13'd1, 1'b0, '0});
        directed.push_back('{32'h7FFF_FFFF, 32'd0, 12'd1, 13'd1, 13'h1FFF, 1'b0, '0});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (50) @(posedge i_clk);

        for (int phase = 0; phase < 13; phase++) begin
            // drain, then leave the pipeline its full depth before touching the camera
            while (pending_proj.size() != 0) @(posedge i_clk);
            i_valid <= 1'b0;
            repeat (80) @(posedge i_clk);
            idle_mode = phase % 4;
            case (phase)
                0: ;
                1: cfg = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_1FFF, 32'h0000_7FFF};
                2: cfg = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_8000};
                3: cfg = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0,
                           32'd0, 32'h8000_0000, 32'd4096, 32'd0};
                4: cfg = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'hFFFF_FFFF};
                5: cfg = '{32'd0, 32'd0, 32'd0, 32'h0001_0000,
                           32'hFFFF_57CA, 32'd0, 32'd1, 32'd0};
                default: begin
                    for (int i = 0; i < 2; i++)
                        cfg[i] = ($urandom_range(9) < 3) ? $urandom : small_signed(24);
                    for (int i = 2; i < 6; i++)
                        cfg[i] = small_signed($urandom_range(10, 18));
                    cfg[6] = ($urandom_range(9) == 0) ? 32'($urandom_range(0, 8191))
                                                      : 32'($urandom_range(1, 4096));
                    cfg[7] = $urandom;
                end
            endcase
            if (phase != 0) write_camera(cfg);
            if (phase == 0) begin
                foreach (directed[i]) send_sprite(directed[i]);
            end
            for (int n = 0; n < 96; n++) send_sprite(random_sprite());
            i_valid <= 1'b0;
        end

        while (pending_proj.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("sprite_screen_projection verification clean");
        end else begin
            $display("sprite_screen_projection verification failed");
        end
        $finish;
    end

    // Hard stop if the pipeline hangs.
    initial begin
        #40_000_000;
        $display("sprite_screen_projection verification failed");
        $finish;
    end

endmodule
